[rtl/min_heap_priority_queue_defines.svh]
// Assertion macros for the heap queue
`ifndef MIN_HEAP_PRIORITY_QUEUE_DEFINES_SVH
`define MIN_HEAP_PRIORITY_QUEUE_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define MHPQ_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`define MHPQ_ASSERT_IMPLY(label, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error(msg);
`define MHPQ_ASSERT_NEXT(label, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);
`else
`define MHPQ_ASSERT_ALWAYS(label, expr, msg)
`define MHPQ_ASSERT_IMPLY(label, cond, expr, msg)
`define MHPQ_ASSERT_NEXT(label, cond, expr, msg)
`endif

`endif

[rtl/mhpq_pkg.sv]
package mhpq_pkg;

    localparam int KEY_W = 32;
    localparam int OCC_W = 8;

    typedef logic [KEY_W-1:0] key_t;
    typedef logic [1:0]       status_t;

    localparam logic    OP_INSERT = 1'b0;
    localparam logic    OP_REMOVE = 1'b1;

    localparam status_t ST_OK    = 2'd0;
    localparam status_t ST_FULL  = 2'd1;
    localparam status_t ST_EMPTY = 2'd2;

endpackage

[rtl/mhpq_ram.sv]
module mhpq_ram #(
    parameter int DEPTH = 128,
    parameter int AW    = 7
) (
    input  logic              clk,
    input  logic              we,
    input  logic [AW-1:0]     waddr,
    input  mhpq_pkg::key_t    wdata,
    input  logic [AW-1:0]     raddr_a,
    input  logic [AW-1:0]     raddr_b,
    output mhpq_pkg::key_t    rdata_a,
    output mhpq_pkg::key_t    rdata_b
);

    mhpq_pkg::key_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

[rtl/min_heap_priority_queue.sv]
// Binary min-heap of signed 32-bit keys, CAPACITY entries in one synchronous RAM.
// Command channel: present operation and key_in with start; the transaction is taken
// at a rising edge with start high and busy low. operation 0 inserts key_in, 1 removes
// the smallest key.
// Result channel: done is high for exactly one cycle with key_out, status and
// occupancy; the receiver cannot stall, so each result must be sampled then.
// An insert walks up one level at a time, each level a RAM read and then a compare
// and write; a remove reads root and last key at the accepting edge, takes them in
// the next cycle and walks down one level at a time in the same way, reading both
// children on the two RAM read ports. A full insert or an empty remove answers
// through the response state. busy stays high until done; one transaction is in
// flight at a time, so a new command is taken only once the last one is done.
// Reset clears the key count and control; RAM contents are not cleared, as only
// data read from positions holding keys is ever used.
`include "min_heap_priority_queue_defines.svh"

module min_heap_priority_queue #(
    parameter int CAPACITY = 128
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic                 operation,
    input  logic signed [31:0]   key_in,
    output logic                 done,
    output logic signed [31:0]   key_out,
    output logic [1:0]           status,
    output logic [7:0]           occupancy
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int AW = $clog2(CAPACITY);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RESP,
        S_UP_ISSUE,
        S_UP_EVAL,
        S_RM_EVAL,
        S_DN_ISSUE,
        S_DN_EVAL
    } state_t;

    state_t               state_reg, state_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [CW-1:0]        pos_reg, pos_next;
    mhpq_pkg::key_t       key_reg, key_next;
    logic                 done_reg, done_next;
    mhpq_pkg::key_t       kout_reg, kout_next;
    mhpq_pkg::status_t    status_reg, status_next;

    logic                 we;
    logic [AW-1:0]        waddr;
    mhpq_pkg::key_t       wdata;
    logic [AW-1:0]        raddr_a, raddr_b;
    mhpq_pkg::key_t       rdata_a, rdata_b;

    logic [CW-1:0]        pos_m1;
    logic [CW-1:0]        parent;
    logic [CW-1:0]        parent_m1;
    logic [CW-1:0]        count_m1;
    logic [CW:0]          left;
    logic [CW:0]          right;
    logic [CW:0]          left_m1;
    logic [CW:0]          count_x;
    logic                 left_ok;
    logic                 right_ok;
    logic                 take_right;
    mhpq_pkg::key_t       child_key;
    logic [CW-1:0]        child_pos;

    mhpq_ram #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_ram (
        .clk     (clk),
        .we      (we),
        .waddr   (waddr),
        .wdata   (wdata),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    assign pos_m1     = pos_reg - CW'(1);
    assign parent     = pos_reg >> 1;
    assign parent_m1  = parent - CW'(1);
    assign count_m1   = count_reg - CW'(1);
    assign left       = {pos_reg, 1'b0};
    assign right      = {pos_reg, 1'b1};
    assign left_m1    = left - (CW+1)'(1);
    assign count_x    = {1'b0, count_reg};
    assign left_ok    = (left <= count_x);
    assign right_ok   = (right <= count_x);
    assign take_right = right_ok && ($signed(rdata_b) < $signed(rdata_a));
    assign child_key  = take_right ? rdata_b : rdata_a;
    assign child_pos  = take_right ? right[CW-1:0] : left[CW-1:0];

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        pos_next    = pos_reg;
        key_next    = key_reg;
        done_next   = 1'b0;
        kout_next   = kout_reg;
        status_next = status_reg;
        we          = 1'b0;
        waddr       = pos_m1[AW-1:0];
        wdata       = key_reg;
        raddr_a     = '0;
        raddr_b     = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    kout_next   = '0;
                    status_next = mhpq_pkg::ST_OK;
                    if (operation == mhpq_pkg::OP_INSERT)
                    begin
                        if (count_reg == CW'(CAPACITY))
                        begin
                            status_next = mhpq_pkg::ST_FULL;
                            state_next  = S_RESP;
                        end
                        else
                        begin
                            count_next = count_reg + CW'(1);
                            pos_next   = count_reg + CW'(1);
                            key_next   = key_in;
                            state_next = S_UP_ISSUE;
                        end
                    end
                    else
                    begin
                        if (count_reg == '0)
                        begin
                            status_next = mhpq_pkg::ST_EMPTY;
                            state_next  = S_RESP;
                        end
                        else
                        begin
                            raddr_a    = '0;
                            raddr_b    = count_m1[AW-1:0];
                            state_next = S_RM_EVAL;
                        end
                    end
                end
            end
            S_RESP:
            begin
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            S_UP_ISSUE:
            begin
                if (pos_reg == CW'(1))
                begin
                    we         = 1'b1;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    raddr_a    = parent_m1[AW-1:0];
                    state_next = S_UP_EVAL;
                end
            end
            S_UP_EVAL:
            begin
                we = 1'b1;
                if ($signed(key_reg) < $signed(rdata_a))
                begin
                    wdata      = rdata_a;
                    pos_next   = parent;
                    state_next = S_UP_ISSUE;
                end
                else
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_RM_EVAL:
            begin
                kout_next  = rdata_a;
                key_next   = rdata_b;
                count_next = count_m1;
                pos_next   = CW'(1);
                if (count_m1 == '0)
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_DN_ISSUE;
                end
            end
            S_DN_ISSUE:
            begin
                if (!left_ok)
                begin
                    we         = 1'b1;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    raddr_a    = left_m1[AW-1:0];
                    raddr_b    = right_ok ? left[AW-1:0] : left_m1[AW-1:0];
                    state_next = S_DN_EVAL;
                end
            end
            S_DN_EVAL:
            begin
                we = 1'b1;
                if ($signed(child_key) < $signed(key_reg))
                begin
                    wdata      = child_key;
                    pos_next   = child_pos;
                    state_next = S_DN_ISSUE;
                end
                else
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            done_reg   <= 1'b0;
            status_reg <= mhpq_pkg::ST_OK;
            kout_reg   <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            done_reg   <= done_next;
            status_reg <= status_next;
            kout_reg   <= kout_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg <= pos_next;
        key_reg <= key_next;
    end

    assign busy      = (state_reg != S_IDLE);
    assign done      = done_reg;
    assign key_out   = kout_reg;
    assign status    = status_reg;
    assign occupancy = 8'(count_reg);

    `MHPQ_ASSERT_ALWAYS(a_count_bound, count_reg <= CW'(CAPACITY), "key count above capacity")
    `MHPQ_ASSERT_NEXT(a_start_busy, start && !busy, busy, "transaction taken but block idle")
    `MHPQ_ASSERT_IMPLY(a_done_busy, done, $past(busy), "result without transaction in flight")
    `MHPQ_ASSERT_IMPLY(a_empty_result, done && status == mhpq_pkg::ST_EMPTY,
        key_out == '0 && count_reg == '0, "empty remove reports key or keys")
    `MHPQ_ASSERT_IMPLY(a_write_range, we, int'(waddr) < CAPACITY, "RAM write beyond capacity")

endmodule

[sim/min_heap_priority_queue_tb.sv]
`timescale 1ns / 1ps

module min_heap_priority_queue_tb;

    localparam int HEAP_DEPTH  = 128;
    localparam int CYCLE_LIMIT = 200000;
    localparam int TAIL_CYCLES = 40;

    typedef struct packed {
        mhpq_pkg::key_t             key;
        mhpq_pkg::status_t          status;
        logic [mhpq_pkg::OCC_W-1:0] occupancy;
    } heap_result_t;

    logic                       clk;
    logic                       rst_n;
    logic                       start;
    logic                       busy;
    logic                       operation;
    logic [31:0]                key_in;
    logic                       done;
    logic [31:0]                key_out;
    logic [1:0]                 status;
    logic [mhpq_pkg::OCC_W-1:0] occupancy;

    mhpq_pkg::key_t shadow_keys [1:HEAP_DEPTH];
    int             shadow_size;
    heap_result_t   owed_results [$];
    int             mismatch_count;
    int             cycle_count;
    int             burst_left;

    min_heap_priority_queue #(
        .CAPACITY(HEAP_DEPTH)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .operation(operation),
        .key_in(key_in),
        .done(done),
        .key_out(key_out),
        .status(status),
        .occupancy(occupancy)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    task automatic apply_to_shadow_heap(input logic op, input mhpq_pkg::key_t key);
        heap_result_t   res;
        int             pos;
        int             child;
        bit             sinking;
        mhpq_pkg::key_t tmp;
        res.key    = '0;
        res.status = mhpq_pkg::ST_OK;
        if (op == mhpq_pkg::OP_INSERT)
        begin
            if (shadow_size >= HEAP_DEPTH)
            begin
                res.status = mhpq_pkg::ST_FULL;
            end
            else
            begin
                shadow_size++;
                shadow_keys[shadow_size] = key;
                pos = shadow_size;
                while (pos > 1 && $signed(shadow_keys[pos]) < $signed(shadow_keys[pos / 2]))
                begin
                    tmp                     = shadow_keys[pos];
                    shadow_keys[pos]        = shadow_keys[pos / 2];
                    shadow_keys[pos / 2]    = tmp;
                    pos                     = pos / 2;
                end
            end
        end
        else if (shadow_size == 0)
        begin
            res.status = mhpq_pkg::ST_EMPTY;
        end
        else
        begin
            res.key        = shadow_keys[1];
            shadow_keys[1] = shadow_keys[shadow_size];
            shadow_size--;
            pos     = 1;
            sinking = 1'b1;
            while (sinking && 2 * pos <= shadow_size)
            begin
                child = 2 * pos;
                if (child + 1 <= shadow_size &&
                    $signed(shadow_keys[child + 1]) < $signed(shadow_keys[child]))
                begin
                    child = child + 1;
                end
                if ($signed(shadow_keys[child]) < $signed(shadow_keys[pos]))
                begin
                    tmp                = shadow_keys[child];
                    shadow_keys[child] = shadow_keys[pos];
                    shadow_keys[pos]   = tmp;
                    pos                = child;
                end
                else
                begin
                    sinking = 1'b0;
                end
            end
        end
        res.occupancy = mhpq_pkg::OCC_W'(shadow_size);
        owed_results.push_back(res);
    endtask

    // hold start until the transaction is taken
    task automatic send_command(input logic op, input mhpq_pkg::key_t key);
        start     <= 1'b1;
        operation <= op;
        key_in    <= key;
        do
        begin
            @(posedge clk);
        end
        while (busy);
        apply_to_shadow_heap(op, key);
    endtask

    task automatic pace_sender();
        int gap;
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            gap   = $urandom_range(1, 6);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = $urandom_range(0, 24);
        end
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (owed_results.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic push_key(input logic op, input mhpq_pkg::key_t key);
        send_command(op, key);
        pace_sender();
    endtask

    function automatic mhpq_pkg::key_t pick_key();
        case ($urandom_range(0, 9))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2, 3:    return mhpq_pkg::key_t'($urandom_range(0, 16) - 32'd8);
            default: return mhpq_pkg::key_t'($urandom());
        endcase
    endfunction

    task automatic test_empty_remove();
        push_key(mhpq_pkg::OP_REMOVE, 32'hFFFF_FFFF);
        push_key(mhpq_pkg::OP_REMOVE, 32'h0000_0000);
    endtask

    task automatic test_extreme_keys();
        push_key(mhpq_pkg::OP_INSERT, 32'h7FFF_FFFF);
        push_key(mhpq_pkg::OP_INSERT, 32'h8000_0000);
        push_key(mhpq_pkg::OP_INSERT, 32'h0000_0000);
        push_key(mhpq_pkg::OP_INSERT, 32'hFFFF_FFFF);
        push_key(mhpq_pkg::OP_INSERT, 32'h0000_0001);
        push_key(mhpq_pkg::OP_INSERT, 32'h0000_0005);
        push_key(mhpq_pkg::OP_INSERT, 32'h0000_0005);
        push_key(mhpq_pkg::OP_INSERT, 32'h0000_0005);
        repeat (9) push_key(mhpq_pkg::OP_REMOVE, 32'h5555_AAAA);
    endtask

    task automatic test_mixed_traffic(input int count, input int insert_pct);
        repeat (count)
        begin
            if ($urandom_range(1, 100) <= insert_pct)
                push_key(mhpq_pkg::OP_INSERT, pick_key());
            else
                push_key(mhpq_pkg::OP_REMOVE, mhpq_pkg::key_t'($urandom()));
        end
    endtask

    task automatic test_fill_to_full();
        test_mixed_traffic(60, 80);
        while (shadow_size < HEAP_DEPTH)
        begin
            push_key(mhpq_pkg::OP_INSERT, pick_key());
        end
        repeat (4) push_key(mhpq_pkg::OP_INSERT, pick_key());
    endtask

    task automatic test_drain_to_empty();
        test_mixed_traffic(60, 20);
        while (shadow_size > 0)
        begin
            push_key(mhpq_pkg::OP_REMOVE, mhpq_pkg::key_t'($urandom()));
        end
        repeat (4) push_key(mhpq_pkg::OP_REMOVE, mhpq_pkg::key_t'($urandom()));
    endtask

    always @(posedge clk)
    begin
        heap_result_t want;
        if (rst_n && done)
        begin
            if (owed_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: key %0d status %0d occupancy %0d",
                             $signed(key_out), status, occupancy);
            end
            else
            begin
                want = owed_results.pop_front();
                if (key_out !== want.key || status !== want.status ||
                    occupancy !== want.occupancy)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display(
                            "mismatch exp key %0d st %0d occ %0d got key %0d st %0d occ %0d",
                            $signed(want.key), want.status, want.occupancy,
                            $signed(key_out), status, occupancy);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL min_heap_priority_queue");
            $finish;
        end
    end

    initial
    begin
        rst_n          = 1'b0;
        start          = 1'b0;
        operation      = mhpq_pkg::OP_INSERT;
        key_in         = '0;
        shadow_size    = 0;
        mismatch_count = 0;
        cycle_count    = 0;
        burst_left     = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_remove();
        test_extreme_keys();
        wait_drained();
        @(posedge clk);
        test_mixed_traffic(150, 55);
        test_fill_to_full();
        wait_drained();
        @(posedge clk);
        test_drain_to_empty();
        test_mixed_traffic(180, 60);
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && owed_results.size() == 0)
        begin
            $display("PASS min_heap_priority_queue");
        end
        else
        begin
            $display("FAIL min_heap_priority_queue");
        end
        $finish;
    end

endmodule

[files.f]
+incdir+rtl
rtl/mhpq_pkg.sv
rtl/mhpq_ram.sv
rtl/min_heap_priority_queue.sv
sim/min_heap_priority_queue_tb.sv
